// ===== src/assert_macros.svh =====
// Assertion macros for the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled in reset
`define ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== src/hpc_pkg.sv =====
// Package for the homogeneous polygon clipper: defaults, codes and plane distance
package hpc_pkg;

  localparam int MAX_VERTICES_DEF  = 16;
  localparam int VARYING_LANES_DEF = 4;
  localparam int RATIO_BITS        = 30;

  localparam logic CFG_NUM_VARYINGS = 1'b0;
  localparam logic CFG_W_EPSILON    = 1'b1;

  localparam logic [2:0] PL_W_EPS = 3'd0;
  localparam logic [2:0] PL_X_POS = 3'd1;
  localparam logic [2:0] PL_X_NEG = 3'd2;
  localparam logic [2:0] PL_Y_POS = 3'd3;
  localparam logic [2:0] PL_Y_NEG = 3'd4;
  localparam logic [2:0] PL_Z_POS = 3'd5;
  localparam logic [2:0] PL_Z_NEG = 3'd6;
  localparam logic [2:0] PL_NONE  = 3'd7;

  function automatic logic signed [33:0] plane_dist(
    input logic [2:0]  pl,
    input logic [31:0] x,
    input logic [31:0] y,
    input logic [31:0] z,
    input logic [31:0] w,
    input logic [15:0] eps
  );
    logic signed [33:0] xe, ye, ze, we, d;
    xe = {{2{x[31]}}, x};
    ye = {{2{y[31]}}, y};
    ze = {{2{z[31]}}, z};
    we = {{2{w[31]}}, w};
    case (pl)
      PL_W_EPS: d = we - $signed({18'd0, eps});
      PL_X_POS: d = we - xe;
      PL_X_NEG: d = we + xe;
      PL_Y_POS: d = we - ye;
      PL_Y_NEG: d = we + ye;
      PL_Z_POS: d = we - ze;
      PL_Z_NEG: d = we + ze;
      default:  d = 34'sd0;
    endcase
    return d;
  endfunction

  // no plane for the spare code: everything is inside
  function automatic logic plane_inside(
    input logic [2:0]  pl,
    input logic [31:0] x,
    input logic [31:0] y,
    input logic [31:0] z,
    input logic [31:0] w,
    input logic [15:0] eps
  );
    logic signed [33:0] d;
    d = plane_dist(pl, x, y, z, w, eps);
    return (pl == PL_NONE) || !d[33];
  endfunction

endpackage

// ===== src/homogeneous_polygon_plane_clipper.sv =====
// Single-plane homogeneous polygon clipper, sequenced over one shared datapath
//
//  channel   handshake            payload
//  vertex    start / busy         vertex_x..w, varying_0..3, plane_select, last_vertex
//  config    cfg_valid/cfg_ready  cfg_index, cfg_data
//  result    out_valid (strobe)   out_x..w, out_varying_0..3, out_last, polygon_empty, overflow
//
// A vertex is stored when start is taken while idle. With three or more vertices, the last
// one starts a count pass over all n vertices, then each edge passes the visit, load and
// distance states; a crossing adds a restoring divide (skipped when the current vertex sits
// on the plane), a multiply and an accumulate step per lane for all 4+VARYING_LANES lanes
// on the shared multiplier and an emit step; a kept vertex takes a copy and an emit step.
// busy stays high through the whole walk. Sync reset clears control state only.
// The result side cannot stall; each result word is shown for one cycle.
module homogeneous_polygon_plane_clipper #(
  parameter int MAX_VERTICES  = hpc_pkg::MAX_VERTICES_DEF,
  parameter int VARYING_LANES = hpc_pkg::VARYING_LANES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic signed [31:0] vertex_x,
  input  logic signed [31:0] vertex_y,
  input  logic signed [31:0] vertex_z,
  input  logic signed [31:0] vertex_w,
  input  logic signed [31:0] varying_0,
  input  logic signed [31:0] varying_1,
  input  logic signed [31:0] varying_2,
  input  logic signed [31:0] varying_3,
  input  logic [2:0]  plane_select,
  input  logic        last_vertex,
  output logic        out_valid,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic signed [31:0] out_w,
  output logic signed [31:0] out_varying_0,
  output logic signed [31:0] out_varying_1,
  output logic signed [31:0] out_varying_2,
  output logic signed [31:0] out_varying_3,
  output logic        out_last,
  output logic        polygon_empty,
  output logic        overflow
);

  localparam int IW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int TW = $clog2(2 * MAX_VERTICES + 1);
  localparam int NL = 4 + VARYING_LANES;
  localparam int LW = $clog2(NL);
  localparam int WW = 32 * NL;
  localparam int RB = hpc_pkg::RATIO_BITS;

  typedef enum logic [3:0] {
    S_IDLE, S_COUNT, S_VISIT, S_LOAD, S_DIST, S_DIV, S_MUL, S_ACC, S_COPY, S_EMIT, S_EMPTY
  } state_t;

  state_t state;

  logic [2:0]  num_varyings;
  logic [15:0] w_epsilon;

  logic [WW-1:0] mem [MAX_VERTICES];
  logic [WW-1:0] rd_p, rd_c;
  logic [IW-1:0] ra_p, ra_c;

  logic [CW-1:0] vertex_count, n, i, k, kmax;
  logic [TW-1:0] total;
  logic [2:0]    held_plane;
  logic          input_overflow, ovf, phase_x, neg;
  logic [MAX_VERTICES-1:0] inside_bits;
  logic [34:0]   den;
  logic [35:0]   rem;
  logic [RB:0]   t;
  logic [4:0]    dcnt;
  logic [LW-1:0] lane;
  logic [63:0]   prod;
  logic [31:0]   res  [NL];
  logic [31:0]   oreg [8];

  logic          acc;
  logic [2:0]    plane_eff, nv;
  logic [WW-1:0] in_word;
  logic [31:0]   vin [4];
  logic          in_bit;
  logic [CW-1:0] n_new, p;
  logic          pin, cin;
  logic [TW-1:0] total_next;
  logic signed [33:0] dp, dc, dd;
  logic [33:0]   abs_dp;
  logic [34:0]   abs_dd;
  logic [35:0]   rem2;
  logic signed [33:0] la, lb, diff;
  logic [32:0]   mag;
  logic [33:0]   q;
  logic [33:0]   lres;
  logic          lane_act;

  function automatic logic lane_on(input int j, input logic [2:0] nvar);
    return (j < 4) || ((j - 4) < int'(nvar));
  endfunction

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign acc       = start && !busy;

  assign vin[0] = varying_0;
  assign vin[1] = varying_1;
  assign vin[2] = varying_2;
  assign vin[3] = varying_3;

  always_comb begin
    in_word = '0;
    in_word[31:0]    = vertex_x;
    in_word[63:32]   = vertex_y;
    in_word[95:64]   = vertex_z;
    in_word[127:96]  = vertex_w;
    for (int j = 0; j < VARYING_LANES; j++) begin
      in_word[32*(4+j) +: 32] = vin[j];
    end
  end

  assign plane_eff = (vertex_count == '0) ? plane_select : held_plane;
  assign in_bit = hpc_pkg::plane_inside(plane_eff, vertex_x, vertex_y, vertex_z, vertex_w,
                                        w_epsilon);
  assign n_new = (vertex_count < CW'(MAX_VERTICES)) ? vertex_count + 1'b1 : vertex_count;
  assign nv = (num_varyings > 3'(VARYING_LANES)) ? 3'(VARYING_LANES) : num_varyings;

  assign p   = (i == '0) ? n - 1'b1 : i - 1'b1;
  assign pin = inside_bits[p[IW-1:0]];
  assign cin = inside_bits[i[IW-1:0]];
  assign total_next = total + TW'(pin != cin) + TW'(cin);

  assign dp = hpc_pkg::plane_dist(held_plane, rd_p[31:0], rd_p[63:32], rd_p[95:64],
                                  rd_p[127:96], w_epsilon);
  assign dc = hpc_pkg::plane_dist(held_plane, rd_c[31:0], rd_c[63:32], rd_c[95:64],
                                  rd_c[127:96], w_epsilon);
  assign dd = dp - dc;
  assign abs_dp = dp[33] ? 34'(-dp) : 34'(dp);
  assign abs_dd = dd[33] ? 35'(-{dd[33], dd}) : {1'b0, dd};
  assign rem2 = {rem[34:0], 1'b0};

  assign la   = {{2{rd_p[32*lane+31]}}, rd_p[32*lane +: 32]};
  assign lb   = {{2{rd_c[32*lane+31]}}, rd_c[32*lane +: 32]};
  assign diff = lb - la;
  assign mag  = diff[33] ? 33'(-diff) : 33'(diff);
  assign q    = 34'((prod + 64'(1 << (RB - 1))) >> RB);
  assign lres = neg ? 34'(la) - q : 34'(la) + q;
  assign lane_act = (lane < LW'(4)) || ((4'(lane) - 4'd4) < 4'(nv));

  always_ff @(posedge clk) begin
    if (acc && (vertex_count < CW'(MAX_VERTICES))) begin
      mem[vertex_count[IW-1:0]] <= in_word;
    end
    rd_p <= mem[ra_p];
    rd_c <= mem[ra_c];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_varyings <= 3'd4;
      w_epsilon    <= 16'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        hpc_pkg::CFG_NUM_VARYINGS: num_varyings <= cfg_data[2:0];
        hpc_pkg::CFG_W_EPSILON:    w_epsilon    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      vertex_count   <= '0;
      held_plane     <= '0;
      input_overflow <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      out_valid <= (state == S_EMIT) || (state == S_EMPTY);
      case (state)
        S_IDLE: begin
          if (acc) begin
            if (vertex_count == '0) held_plane <= plane_select;
            if (vertex_count < CW'(MAX_VERTICES)) begin
              inside_bits[vertex_count[IW-1:0]] <= in_bit;
            end
            if (last_vertex) begin
              n              <= n_new;
              ovf            <= input_overflow || (vertex_count == CW'(MAX_VERTICES));
              vertex_count   <= '0;
              input_overflow <= 1'b0;
              i              <= '0;
              total          <= '0;
              state          <= (n_new >= CW'(3)) ? S_COUNT : S_EMPTY;
            end else begin
              vertex_count <= n_new;
              if (vertex_count == CW'(MAX_VERTICES)) input_overflow <= 1'b1;
            end
          end
        end
        S_COUNT: begin
          total <= total_next;
          if (i == n - 1'b1) begin
            kmax  <= (total_next > TW'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : CW'(total_next);
            ovf   <= ovf || (total_next > TW'(MAX_VERTICES));
            i     <= '0;
            k     <= '0;
            state <= (total_next == '0) ? S_EMPTY : S_VISIT;
          end else begin
            i <= i + 1'b1;
          end
        end
        S_VISIT: begin
          ra_p  <= p[IW-1:0];
          ra_c  <= i[IW-1:0];
          state <= S_LOAD;
        end
        S_LOAD: state <= S_DIST;
        S_DIST: begin
          lane <= '0;
          if (pin != cin) begin
            phase_x <= 1'b1;
            den     <= abs_dd;
            rem     <= {2'b0, abs_dp};
            dcnt    <= '0;
            if ({1'b0, abs_dp} == abs_dd) begin
              t     <= (RB+1)'(1) << RB;
              state <= S_MUL;
            end else begin
              t     <= '0;
              state <= S_DIV;
            end
          end else if (cin) begin
            state <= S_COPY;
          end else begin
            i     <= i + 1'b1;
            state <= S_VISIT;
          end
        end
        S_DIV: begin
          // restoring divide, one quotient bit a cycle
          if (rem2 >= {1'b0, den}) begin
            rem <= rem2 - {1'b0, den};
            t   <= {t[RB-1:0], 1'b1};
          end else begin
            rem <= rem2;
            t   <= {t[RB-1:0], 1'b0};
          end
          dcnt <= dcnt + 1'b1;
          if (dcnt == 5'(RB - 1)) state <= S_MUL;
        end
        S_MUL: begin
          prod  <= 64'(mag) * 64'(t);
          neg   <= diff[33];
          state <= S_ACC;
        end
        S_ACC: begin
          res[lane] <= lane_act ? lres[31:0] : 32'd0;
          if (lane == LW'(NL - 1)) begin
            state <= S_EMIT;
          end else begin
            lane  <= lane + 1'b1;
            state <= S_MUL;
          end
        end
        S_COPY: begin
          for (int j = 0; j < NL; j++) begin
            res[j] <= lane_on(j, nv) ? rd_c[32*j +: 32] : 32'd0;
          end
          phase_x <= 1'b0;
          state   <= S_EMIT;
        end
        S_EMIT: begin
          for (int j = 0; j < 8; j++) begin
            oreg[j] <= (j < NL) ? res[j] : 32'd0;
          end
          out_last      <= (k == kmax - 1'b1);
          polygon_empty <= 1'b0;
          overflow      <= ovf;
          k             <= k + 1'b1;
          if (k == kmax - 1'b1) begin
            state <= S_IDLE;
          end else if (phase_x && cin) begin
            state <= S_COPY;
          end else begin
            i     <= i + 1'b1;
            state <= S_VISIT;
          end
        end
        S_EMPTY: begin
          for (int j = 0; j < 8; j++) begin
            oreg[j] <= 32'd0;
          end
          out_last      <= 1'b1;
          polygon_empty <= 1'b1;
          overflow      <= ovf;
          state         <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_x         = oreg[0];
  assign out_y         = oreg[1];
  assign out_z         = oreg[2];
  assign out_w         = oreg[3];
  assign out_varying_0 = oreg[4];
  assign out_varying_1 = oreg[5];
  assign out_varying_2 = oreg[6];
  assign out_varying_3 = oreg[7];

endmodule

// ===== src/hpc_checker.sv =====
// Port-level checker for the polygon clipper, bound to the top level
`include "assert_macros.svh"

module hpc_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        last_vertex,
  input logic        out_valid,
  input logic        out_last,
  input logic        polygon_empty,
  input logic [31:0] out_x,
  input logic [31:0] out_w
);

  `ASSERT_IMP(a_empty_is_last, clk, rst, out_valid && polygon_empty, out_last)
  `ASSERT_IMP(a_empty_zero, clk, rst, out_valid && polygon_empty,
    (out_x == 32'd0) && (out_w == 32'd0))
  `ASSERT_NXT(a_last_ends, clk, rst, out_valid && out_last, !out_valid)
  `ASSERT_NXT(a_mid_quiet, clk, rst, start && !busy && !last_vertex, !out_valid && !busy)

endmodule

bind homogeneous_polygon_plane_clipper hpc_checker u_hpc_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .last_vertex   (last_vertex),
  .out_valid     (out_valid),
  .out_last      (out_last),
  .polygon_empty (polygon_empty),
  .out_x         (out_x),
  .out_w         (out_w)
);

// ===== tb/tb.sv =====
// Self-checking testbench for the single-plane homogeneous polygon clipper
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAXV = hpc_pkg::MAX_VERTICES_DEF;
  localparam int LANES = hpc_pkg::VARYING_LANES_DEF;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct packed {
    logic [7:0][31:0] val;
    logic             last;
    logic             empty;
    logic             ovf;
  } clip_vertex_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = hpc_pkg::CFG_NUM_VARYINGS;
  logic [15:0] cfg_data = '0;
  logic signed [31:0] vertex_x = '0, vertex_y = '0, vertex_z = '0, vertex_w = '0;
  logic signed [31:0] varying_0 = '0, varying_1 = '0, varying_2 = '0, varying_3 = '0;
  logic [2:0] plane_select = '0;
  logic last_vertex = 1'b0;
  logic out_valid;
  logic signed [31:0] out_x, out_y, out_z, out_w;
  logic signed [31:0] out_varying_0, out_varying_1, out_varying_2, out_varying_3;
  logic out_last, polygon_empty, overflow;

  homogeneous_polygon_plane_clipper dut (.*);

  always #5 clk = ~clk;

  // predictor state
  int        coord_mem [MAXV][4];
  int        vary_mem  [MAXV][LANES];
  int        stored_cnt = 0;
  logic [2:0] poly_plane = '0;
  bit        dropped = 0;
  int        lanes_cfg = 4;
  int        eps_cfg = 1;

  clip_vertex_t clipped_q[$];
  int errors = 0;
  int idle_pct = 0;
  longint cycles = 0;
  string field_names [8] = '{"out_x", "out_y", "out_z", "out_w", "out_varying_0",
                             "out_varying_1", "out_varying_2", "out_varying_3"};

  function automatic longint plane_distance(int v, logic [2:0] pl);
    longint x, y, z, w;
    x = coord_mem[v][0]; y = coord_mem[v][1];
    z = coord_mem[v][2]; w = coord_mem[v][3];
    case (pl)
      hpc_pkg::PL_W_EPS: return w - eps_cfg;
      hpc_pkg::PL_X_POS: return w - x;
      hpc_pkg::PL_X_NEG: return w + x;
      hpc_pkg::PL_Y_POS: return w - y;
      hpc_pkg::PL_Y_NEG: return w + y;
      hpc_pkg::PL_Z_POS: return w - z;
      hpc_pkg::PL_Z_NEG: return w + z;
      default:  return 0;
    endcase
  endfunction

  function automatic bit is_inside(int v, logic [2:0] pl);
    return (pl == hpc_pkg::PL_NONE) || (plane_distance(v, pl) >= 0);
  endfunction

  function automatic logic [95:0] crossing_ratio(int p, int c, logic [2:0] pl);
    longint dp, dc, dd;
    logic [95:0] num, den, t;
    dp = plane_distance(p, pl);
    dc = plane_distance(c, pl);
    dd = dp - dc;
    num = (dp < 0) ? 96'(-dp) : 96'(dp);
    den = (dd < 0) ? 96'(-dd) : 96'(dd);
    if (den == 0) return '0;
    t = (num << hpc_pkg::RATIO_BITS) / den;
    if (t > (96'd1 << hpc_pkg::RATIO_BITS)) t = 96'd1 << hpc_pkg::RATIO_BITS;
    return t;
  endfunction

  function automatic logic [31:0] interp(longint a, longint b, logic [95:0] t);
    longint diff;
    logic [95:0] m, q;
    diff = b - a;
    m = (diff < 0) ? 96'(-diff) : 96'(diff);
    q = (m * t + (96'd1 << (hpc_pkg::RATIO_BITS - 1))) >> hpc_pkg::RATIO_BITS;
    return (diff < 0) ? 32'(a - longint'(q)) : 32'(a + longint'(q));
  endfunction

  // walk the stored polygon and queue the clipped vertices
  task automatic clip_polygon();
    int n, p, nv, j;
    bit ovf, trunc, pin, cin;
    logic [95:0] t;
    clip_vertex_t r, res[$];
    n = stored_cnt; ovf = dropped; trunc = 0;
    stored_cnt = 0; dropped = 0;
    nv = (lanes_cfg > LANES) ? LANES : lanes_cfg;
    if (n >= 3) begin
      for (int i = 0; i < n; i++) begin
        p = (i == 0) ? n - 1 : i - 1;
        pin = is_inside(p, poly_plane);
        cin = is_inside(i, poly_plane);
        if (pin != cin) begin
          r = '0;
          t = crossing_ratio(p, i, poly_plane);
          for (j = 0; j < 4; j++) r.val[j] = interp(coord_mem[p][j], coord_mem[i][j], t);
          for (j = 0; j < nv; j++) r.val[4+j] = interp(vary_mem[p][j], vary_mem[i][j], t);
          if (res.size() < MAXV) res.push_back(r); else trunc = 1;
        end
        if (cin) begin
          r = '0;
          for (j = 0; j < 4; j++) r.val[j] = coord_mem[i][j];
          for (j = 0; j < nv; j++) r.val[4+j] = vary_mem[i][j];
          if (res.size() < MAXV) res.push_back(r); else trunc = 1;
        end
      end
    end
    if (res.size() == 0) begin
      r = '0;
      r.empty = 1'b1;
      res.push_back(r);
    end
    foreach (res[k]) begin
      res[k].last = (k == res.size() - 1);
      res[k].ovf = ovf || trunc;
      clipped_q.push_back(res[k]);
    end
  endtask

  task automatic load_vertex(int f[8], logic [2:0] ps, bit lst);
    if (stored_cnt == 0) poly_plane = ps;
    if (stored_cnt < MAXV) begin
      for (int j = 0; j < 4; j++) coord_mem[stored_cnt][j] = f[j];
      for (int j = 0; j < LANES; j++) vary_mem[stored_cnt][j] = f[4+j];
      stored_cnt++;
    end else begin
      dropped = 1;
    end
    if (lst) clip_polygon();
  endtask

  // send one vertex word; start is left high for a following word
  task automatic send_vertex(int f[8], logic [2:0] ps, bit lst);
    int gap;
    if ($urandom_range(99) < idle_pct) begin
      gap = $urandom_range(1, 4);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    vertex_x <= f[0]; vertex_y <= f[1]; vertex_z <= f[2]; vertex_w <= f[3];
    varying_0 <= f[4]; varying_1 <= f[5]; varying_2 <= f[6]; varying_3 <= f[7];
    plane_select <= ps;
    last_vertex <= lst;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    load_vertex(f, ps, lst);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (clipped_q.size() != 0 || busy) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_cfg(logic idx, logic [15:0] data);
    drain();
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == hpc_pkg::CFG_NUM_VARYINGS) lanes_cfg = data & 7;
    else eps_cfg = data;
  endtask

  function automatic int rand_val(bit positive);
    int v;
    case ($urandom_range(3))
      0: v = $urandom;
      1: v = int'($urandom_range(0, 32'h0040_0000)) - 32'h0020_0000;
      default: v = int'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000;
    endcase
    if (positive && v < 0 && $urandom_range(3) != 0) v = -(v >>> 1);
    return v;
  endfunction

  task automatic send_polygon(int n, logic [2:0] pl);
    int f[8];
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < 8; j++) f[j] = rand_val(j == 3);
      send_vertex(f, (i == 0) ? pl : 3'($urandom), i == n - 1);
    end
  endtask

  task automatic test_extremes();
    int f[8];
    int ext[4] = '{32'h8000_0000, 32'h7FFF_FFFF, 0, -1};
    for (int k = 0; k < 4; k++) begin
      for (int i = 0; i < 3; i++) begin
        foreach (f[j]) f[j] = ext[(k + i + j) % 4];
        send_vertex(f, 3'(k * 2 + 1), i == 2);
      end
    end
    for (int pl = 0; pl < 8; pl++) send_polygon(3, 3'(pl));
  endtask

  task automatic test_short_polygons();
    send_polygon(1, hpc_pkg::PL_X_POS);
    send_polygon(2, hpc_pkg::PL_W_EPS);
    send_polygon(2, hpc_pkg::PL_NONE);
  endtask

  task automatic test_overflow();
    int f[8];
    send_polygon(19, hpc_pkg::PL_NONE);
    // alternating sides of x<=w: many crossings, output exceeds capacity
    for (int i = 0; i < 16; i++) begin
      f = '{(i % 2) ? 32'h0003_0000 : 32'h0000_8000, i * 32'h100, 0, 32'h0001_0000,
            i, -i, i * 7, 32'h7FFF_FFFF};
      send_vertex(f, hpc_pkg::PL_X_POS, i == 15);
    end
  endtask

  task automatic test_random(int items);
    int sent, n;
    sent = 0;
    while (sent < items) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(1, 20) : $urandom_range(3, 7);
      send_polygon(n, 3'($urandom));
      sent += n;
    end
  endtask

  // every result strobe must match the oldest queued vertex
  always @(posedge clk) begin
    clip_vertex_t e;
    logic [7:0][31:0] got;
    if (!rst && out_valid) begin
      got = {out_varying_3, out_varying_2, out_varying_1, out_varying_0,
             out_w, out_z, out_y, out_x};
      if (clipped_q.size() == 0) begin
        $error("unexpected result word");
        errors++;
      end else begin
        e = clipped_q.pop_front();
        for (int j = 0; j < 8; j++)
          if (got[j] !== e.val[j]) begin
            $error("%s expected %h actual %h", field_names[j], e.val[j], got[j]);
            errors++;
          end
        if (out_last !== e.last) begin
          $error("out_last expected %b actual %b", e.last, out_last); errors++;
        end
        if (polygon_empty !== e.empty) begin
          $error("polygon_empty expected %b actual %b", e.empty, polygon_empty); errors++;
        end
        if (overflow !== e.ovf) begin
          $error("overflow expected %b actual %b", e.ovf, overflow); errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    idle_pct = 20;
    test_extremes();
    test_short_polygons();
    test_overflow();
    write_cfg(hpc_pkg::CFG_NUM_VARYINGS, 16'd0);
    write_cfg(hpc_pkg::CFG_W_EPSILON, 16'd0);
    test_random(30);
    write_cfg(hpc_pkg::CFG_NUM_VARYINGS, 16'd7);
    write_cfg(hpc_pkg::CFG_W_EPSILON, 16'hFFFF);
    idle_pct = 51;
    test_random(40);
    write_cfg(hpc_pkg::CFG_NUM_VARYINGS, 16'd2);
    write_cfg(hpc_pkg::CFG_W_EPSILON, 16'h1234);
    idle_pct = 0;
    test_random(35);
    write_cfg(hpc_pkg::CFG_NUM_VARYINGS, 16'd4);
    test_random(35);
    drain();
    if (errors == 0 && clipped_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
